// ----- hdl/ctgu_pkg.sv -----
// ----------------------------------------------------------------------------
// ctgu_pkg
// Shared widths, command and gate codes for the tableau gate update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctgu_pkg;

  localparam int QUBITS_DEF = 16;

  localparam int CMD_W  = 3;
  localparam int GATE_W = 3;
  localparam int IDX_W  = 4;
  localparam int WORD_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_GATE   = 3'd0,
    CMD_CNOT   = 3'd1,
    CMD_WCOL   = 3'd2,
    CMD_WPHASE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [GATE_W-1:0] {
    GATE_NONE = 3'd0,
    GATE_X    = 3'd1,
    GATE_Y    = 3'd2,
    GATE_Z    = 3'd3,
    GATE_H    = 3'd4,
    GATE_S    = 3'd5,
    GATE_SDG  = 3'd6
  } gate_t;

endpackage

`default_nettype wire

// ----- hdl/clifford_tableau_gate_update.sv -----
// ----------------------------------------------------------------------------
// clifford_tableau_gate_update
// Pipeline: column RAM read into stage 1, then update into output registers.
// One beat per cycle unless out_ready stalls; writes bypass to the next beat.
// Reset clears the phase vector and, via per-entry valid bits, all columns.
// ----------------------------------------------------------------------------
`default_nettype none

module clifford_tableau_gate_update #(
  parameter int QUBITS = ctgu_pkg::QUBITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ctgu_pkg::CMD_W-1:0]  in_command,
  input  wire logic [ctgu_pkg::GATE_W-1:0] in_gate_kind,
  input  wire logic [ctgu_pkg::IDX_W-1:0]  in_qubit_index,
  input  wire logic [ctgu_pkg::IDX_W-1:0]  in_target_index,
  input  wire logic [ctgu_pkg::WORD_W-1:0] in_x_word,
  input  wire logic [ctgu_pkg::WORD_W-1:0] in_z_word,
  input  wire logic [ctgu_pkg::WORD_W-1:0] in_phase_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ctgu_pkg::WORD_W-1:0] out_x_column,
  output logic      [ctgu_pkg::WORD_W-1:0] out_z_column,
  output logic      [ctgu_pkg::WORD_W-1:0] out_phase_vector,
  output logic                             out_error_flag
);

  import ctgu_pkg::*;

  localparam int AW    = $clog2(QUBITS);
  localparam int EXT_W = IDX_W + AW;
  localparam int WX_W  = WORD_W + QUBITS;

  logic              s1_vld_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [GATE_W-1:0] s1_kind_r;
  logic [IDX_W-1:0]  s1_q_r;
  logic [IDX_W-1:0]  s1_t_r;
  logic [WORD_W-1:0] s1_xw_r;
  logic [WORD_W-1:0] s1_zw_r;
  logic [WORD_W-1:0] s1_pw_r;

  logic              out_vld_r;
  logic [WORD_W-1:0] out_x_r;
  logic [WORD_W-1:0] out_z_r;
  logic [WORD_W-1:0] out_p_r;
  logic              out_err_r;

  logic [QUBITS-1:0] phase_r;
  logic [QUBITS-1:0] x_vld_r;
  logic [QUBITS-1:0] z_vld_r;

  logic              byp_x_en_r;
  logic [AW-1:0]     byp_x_addr_r;
  logic [QUBITS-1:0] byp_x_data_r;
  logic              byp_z_en_r;
  logic [AW-1:0]     byp_z_addr_r;
  logic [QUBITS-1:0] byp_z_data_r;

  logic              load;
  logic              s1_adv;
  logic              out_take;

  logic [EXT_W-1:0]  in_q_ext;
  logic [EXT_W-1:0]  in_t_ext;
  logic [EXT_W-1:0]  s1_q_ext;
  logic [EXT_W-1:0]  s1_t_ext;
  logic [AW-1:0]     rd_q_addr;
  logic [AW-1:0]     rd_t_addr;
  logic [AW-1:0]     s1_qa;
  logic [AW-1:0]     s1_ta;
  logic              q_ok;
  logic              t_ok;

  logic [QUBITS-1:0] ram_xq;
  logic [QUBITS-1:0] ram_xt;
  logic [QUBITS-1:0] ram_zq;
  logic [QUBITS-1:0] ram_zt;
  logic [QUBITS-1:0] xq;
  logic [QUBITS-1:0] xt;
  logic [QUBITS-1:0] zq;
  logic [QUBITS-1:0] zt;

  logic [WX_W-1:0]   xw_ext;
  logic [WX_W-1:0]   zw_ext;
  logic [WX_W-1:0]   pw_ext;

  logic              x_we;
  logic [AW-1:0]     x_waddr;
  logic [QUBITS-1:0] x_wdata;
  logic              z_we;
  logic [AW-1:0]     z_waddr;
  logic [QUBITS-1:0] z_wdata;
  logic [QUBITS-1:0] phase_nxt;
  logic              err_nxt;
  logic [QUBITS-1:0] col_x;
  logic [QUBITS-1:0] col_z;
  logic [WX_W-1:0]   col_x_ext;
  logic [WX_W-1:0]   col_z_ext;
  logic [WX_W-1:0]   phase_ext;

  // handshake
  assign out_take = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_take;
  assign in_ready = !s1_vld_r || s1_adv;
  assign load     = in_valid && in_ready;

  // address forming
  assign in_q_ext  = {AW'(0), in_qubit_index};
  assign in_t_ext  = {AW'(0), in_target_index};
  assign s1_q_ext  = {AW'(0), s1_q_r};
  assign s1_t_ext  = {AW'(0), s1_t_r};
  assign s1_qa     = s1_q_ext[AW-1:0];
  assign s1_ta     = s1_t_ext[AW-1:0];
  assign rd_q_addr = load ? in_q_ext[AW-1:0] : s1_qa;
  assign rd_t_addr = load ? in_t_ext[AW-1:0] : s1_ta;
  assign q_ok      = {1'b0, s1_q_ext} < (EXT_W+1)'(QUBITS);
  assign t_ok      = {1'b0, s1_t_ext} < (EXT_W+1)'(QUBITS);

  ctgu_ram #(
    .WIDTH (QUBITS),
    .DEPTH (QUBITS)
  ) u_x_ram (
    .clk       (clk),
    .wr_en     (x_we && s1_adv),
    .wr_addr   (x_waddr),
    .wr_data   (x_wdata),
    .rd_addr_a (rd_q_addr),
    .rd_addr_b (rd_t_addr),
    .rd_data_a (ram_xq),
    .rd_data_b (ram_xt)
  );

  ctgu_ram #(
    .WIDTH (QUBITS),
    .DEPTH (QUBITS)
  ) u_z_ram (
    .clk       (clk),
    .wr_en     (z_we && s1_adv),
    .wr_addr   (z_waddr),
    .wr_data   (z_wdata),
    .rd_addr_a (rd_q_addr),
    .rd_addr_b (rd_t_addr),
    .rd_data_a (ram_zq),
    .rd_data_b (ram_zt)
  );

  // forward last beat's write, zero for never-written entries
  always_comb begin
    if (byp_x_en_r && byp_x_addr_r == s1_qa) begin
      xq = byp_x_data_r;
    end else begin
      xq = x_vld_r[s1_qa] ? ram_xq : '0;
    end
    if (byp_x_en_r && byp_x_addr_r == s1_ta) begin
      xt = byp_x_data_r;
    end else begin
      xt = x_vld_r[s1_ta] ? ram_xt : '0;
    end
    if (byp_z_en_r && byp_z_addr_r == s1_qa) begin
      zq = byp_z_data_r;
    end else begin
      zq = z_vld_r[s1_qa] ? ram_zq : '0;
    end
    if (byp_z_en_r && byp_z_addr_r == s1_ta) begin
      zt = byp_z_data_r;
    end else begin
      zt = z_vld_r[s1_ta] ? ram_zt : '0;
    end
  end

  assign xw_ext = {QUBITS'(0), s1_xw_r};
  assign zw_ext = {QUBITS'(0), s1_zw_r};
  assign pw_ext = {QUBITS'(0), s1_pw_r};

  // column update
  always_comb begin
    x_we      = 1'b0;
    x_waddr   = (s1_cmd_r == CMD_CNOT) ? s1_ta : s1_qa;
    x_wdata   = xq;
    z_we      = 1'b0;
    z_waddr   = s1_qa;
    z_wdata   = zq;
    phase_nxt = phase_r;
    err_nxt   = 1'b0;
    case (s1_cmd_r)
      CMD_GATE: begin
        if (q_ok) begin
          case (s1_kind_r)
            GATE_X:   phase_nxt = phase_r ^ zq;
            GATE_Y:   phase_nxt = phase_r ^ xq ^ zq;
            GATE_Z:   phase_nxt = phase_r ^ xq;
            GATE_H: begin
              phase_nxt = phase_r ^ (xq & zq);
              x_we      = 1'b1;
              x_wdata   = zq;
              z_we      = 1'b1;
              z_wdata   = xq;
            end
            GATE_S: begin
              phase_nxt = phase_r ^ (xq & zq);
              z_we      = 1'b1;
              z_wdata   = zq ^ xq;
            end
            GATE_SDG: begin
              phase_nxt = phase_r ^ (xq & ~zq);
              z_we      = 1'b1;
              z_wdata   = zq ^ xq;
            end
            default: ;
          endcase
        end
      end
      CMD_CNOT: begin
        if (s1_q_r == s1_t_r) begin
          err_nxt = 1'b1;
        end else if (q_ok && t_ok) begin
          phase_nxt = phase_r ^ (xq & zt & ~(xt ^ zq));
          x_we      = 1'b1;
          x_wdata   = xt ^ xq;
          z_we      = 1'b1;
          z_wdata   = zq ^ zt;
        end
      end
      CMD_WCOL: begin
        if (q_ok) begin
          x_we    = 1'b1;
          x_wdata = xw_ext[QUBITS-1:0];
          z_we    = 1'b1;
          z_wdata = zw_ext[QUBITS-1:0];
        end
      end
      CMD_WPHASE: phase_nxt = pw_ext[QUBITS-1:0];
      default: ;
    endcase
  end

  // columns of the named qubit after the step
  always_comb begin
    col_x = (x_we && x_waddr == s1_qa) ? x_wdata : xq;
    col_z = (z_we && z_waddr == s1_qa) ? z_wdata : zq;
    if (!q_ok) begin
      col_x = '0;
      col_z = '0;
    end
  end

  assign col_x_ext = {WORD_W'(0), col_x};
  assign col_z_ext = {WORD_W'(0), col_z};
  assign phase_ext = {WORD_W'(0), phase_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= '0;
      x_vld_r    <= '0;
      z_vld_r    <= '0;
      byp_x_en_r <= 1'b0;
      byp_z_en_r <= 1'b0;
    end else begin
      if (load) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        phase_r <= phase_nxt;
        if (x_we) begin
          x_vld_r[x_waddr] <= 1'b1;
        end
        if (z_we) begin
          z_vld_r[z_waddr] <= 1'b1;
        end
      end
      byp_x_en_r <= s1_adv && x_we;
      byp_z_en_r <= s1_adv && z_we;
    end
  end

  always_ff @(posedge clk) begin
    byp_x_addr_r <= x_waddr;
    byp_x_data_r <= x_wdata;
    byp_z_addr_r <= z_waddr;
    byp_z_data_r <= z_wdata;
    if (load) begin
      s1_cmd_r  <= in_command;
      s1_kind_r <= in_gate_kind;
      s1_q_r    <= in_qubit_index;
      s1_t_r    <= in_target_index;
      s1_xw_r   <= in_x_word;
      s1_zw_r   <= in_z_word;
      s1_pw_r   <= in_phase_word;
    end
    if (s1_adv) begin
      out_x_r   <= col_x_ext[WORD_W-1:0];
      out_z_r   <= col_z_ext[WORD_W-1:0];
      out_p_r   <= phase_ext[WORD_W-1:0];
      out_err_r <= err_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_x_column     = out_x_r;
  assign out_z_column     = out_z_r;
  assign out_phase_vector = out_p_r;
  assign out_error_flag   = out_err_r;

endmodule

`default_nettype wire

// ----- hdl/ctgu_ram.sv -----
// ----------------------------------------------------------------------------
// ctgu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire
